>>> design/mdmc_pkg.sv
// ----------------------------------------------------------------------------
// MESI direct-mapped cache package
// Shared types, codes and sizes for the snooping cache front end and engine.
// ----------------------------------------------------------------------------
`default_nettype none

package mdmc_pkg;

  // Default geometry.
  localparam int NUM_LINES_DEF = 16;
  localparam int ADDR_BITS_DEF = 16;

  // Fixed field widths of the item and result streams.
  localparam int ADDR_W  = 16;
  localparam int DATA_W  = 64;
  localparam int KIND_W  = 3;

  // Stream bus widths (tdata padded to whole bytes).
  localparam int S_TDATA_W   = 144;
  localparam int M_FIELDS_W  = 132;
  localparam int M_TDATA_W   = 136;

  // Decoupling queue between the front end and the engine.
  localparam int QDEPTH = 4;

  // Raw access kinds as they arrive on the bus.
  localparam logic [KIND_W-1:0] KIND_LOAD      = 3'd0;
  localparam logic [KIND_W-1:0] KIND_STORE     = 3'd1;
  localparam logic [KIND_W-1:0] KIND_SNP_RD    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_SNP_RDX   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_SNP_UPGR  = 3'd4;

  // Classified operation; OP_NONE covers the unused kind codes.
  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_STORE,
    OP_SNP_RD,
    OP_SNP_RDX,
    OP_SNP_UPGR
  } op_e;

  typedef enum logic [1:0] {
    ST_INVALID   = 2'd0,
    ST_SHARED    = 2'd1,
    ST_EXCLUSIVE = 2'd2,
    ST_MODIFIED  = 2'd3
  } line_state_e;

  typedef enum logic [1:0] {
    BUS_NONE = 2'd0,
    BUS_RD   = 2'd1,
    BUS_RDX  = 2'd2,
    BUS_UPGR = 2'd3
  } bus_req_e;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC
  } eng_state_e;

  // Head of the decoupling queue as seen by the engine.
  typedef struct packed {
    logic              valid;
    op_e               op;
    logic [DATA_W-1:0] wdata;
    logic [DATA_W-1:0] mdata;
  } q_head_t;

  // Engine status toward the front end.
  typedef struct packed {
    logic clearing;
    logic pop;
  } eng_status_t;

endpackage : mdmc_pkg

`default_nettype wire

>>> design/mesi_direct_mapped_cache.sv
// ----------------------------------------------------------------------------
// MESI direct-mapped cache
// Write-through, direct-mapped snooping cache with MESI line states, taking
// local loads and stores and snooped bus transactions on one item stream.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake                       Payload
// s_axis    in         s_axis_tvalid / s_axis_tready   tuser: kind; tdata: address,
//                                                      write_data, mem_data
// m_axis    out        m_axis_tvalid / m_axis_tready   tdata: read_data, hit,
//                                                      bus_request, mem_write,
//                                                      mem_write_data
//
// After reset the line store is swept to Invalid, one line per cycle;
// s_axis_tready stays low for that time.
// The front end registers an item with the quotient of its address, then
// works out the line index and queues it, so it takes a new transfer every
// cycle while the queue has room. The engine then handles one access at a
// time: it reads the line from the line store, then updates it and loads the
// result register, and it takes no new access until it is through with the last.
// A stalled result register holds the engine; the queue keeps taking input
// until it fills.
// ----------------------------------------------------------------------------
`default_nettype none

module mesi_direct_mapped_cache
  import mdmc_pkg::*;
#(
  parameter int NUM_LINES = NUM_LINES_DEF,
  parameter int ADDR_BITS = ADDR_BITS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // Access stream.
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  // [15:0] address, [79:16] write_data, [143:80] mem_data
  input  wire logic [S_TDATA_W-1:0] s_axis_tdata,
  // [2:0] kind
  input  wire logic [KIND_W-1:0]    s_axis_tuser,
  // Result stream.
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  // [63:0] read_data, [64] hit, [66:65] bus_request, [67] mem_write,
  // [131:68] mem_write_data, [135:132] zero
  output logic [M_TDATA_W-1:0]      m_axis_tdata
);

  localparam int AW      = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
  localparam int IDX_W   = $clog2(NUM_LINES);
  localparam int TAG_CNT = ((1 << AW) - 1) / NUM_LINES + 1;
  localparam int TAG_W   = ($clog2(TAG_CNT) < 1) ? 1 : $clog2(TAG_CNT);
  localparam int M_PAD_W = M_TDATA_W - M_FIELDS_W;

  eng_status_t       status;
  q_head_t           head;
  logic [IDX_W-1:0]  head_idx;
  logic [TAG_W-1:0]  head_tag;

  logic [DATA_W-1:0] read_data, mem_write_data;
  logic              hit, mem_write;
  bus_req_e          bus_request;

  // Front end: accept, classify the kind, split the address, queue.
  mdmc_front #(
    .NUM_LINES (NUM_LINES),
    .ADDR_BITS (ADDR_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .kind_i       (s_axis_tuser),
    .address_i    (s_axis_tdata[ADDR_W-1:0]),
    .write_data_i (s_axis_tdata[ADDR_W +: DATA_W]),
    .mem_data_i   (s_axis_tdata[ADDR_W + DATA_W +: DATA_W]),
    .status_i     (status),
    .head_o       (head),
    .head_idx_o   (head_idx),
    .head_tag_o   (head_tag)
  );

  // Engine: line store, MESI transitions and the result register.
  mdmc_engine #(
    .NUM_LINES (NUM_LINES),
    .ADDR_BITS (ADDR_BITS)
  ) u_engine (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .head_i           (head),
    .head_idx_i       (head_idx),
    .head_tag_i       (head_tag),
    .status_o         (status),
    .out_valid_o      (m_axis_tvalid),
    .out_ready_i      (m_axis_tready),
    .read_data_o      (read_data),
    .hit_o            (hit),
    .bus_request_o    (bus_request),
    .mem_write_o      (mem_write),
    .mem_write_data_o (mem_write_data)
  );

  // Result fields packed from the lowest bit up.
  assign m_axis_tdata = {{M_PAD_W{1'b0}}, mem_write_data, mem_write, bus_request, hit,
                         read_data};

endmodule : mesi_direct_mapped_cache

`default_nettype wire

>>> design/mdmc_front.sv
// ----------------------------------------------------------------------------
// MESI cache front end
// Accepts accesses, classifies the kind, splits the address into line index
// and tag, and buffers the result in a short queue for the engine.
// ----------------------------------------------------------------------------
`default_nettype none

module mdmc_front
  import mdmc_pkg::*;
#(
  parameter int NUM_LINES = NUM_LINES_DEF,
  parameter int ADDR_BITS = ADDR_BITS_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [KIND_W-1:0]   kind_i,
  input  wire logic [ADDR_W-1:0]   address_i,
  input  wire logic [DATA_W-1:0]   write_data_i,
  input  wire logic [DATA_W-1:0]   mem_data_i,
  input  wire eng_status_t         status_i,
  output q_head_t                  head_o,
  output logic [$clog2(NUM_LINES)-1:0] head_idx_o,
  output logic [((($clog2(((1 << ((ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W)) - 1)
                  / NUM_LINES + 1)) < 1) ? 1
                 : $clog2(((1 << ((ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W)) - 1)
                  / NUM_LINES + 1)) - 1:0] head_tag_o
);

  localparam int AW      = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
  localparam int IDX_W   = $clog2(NUM_LINES);
  localparam int TAG_CNT = ((1 << AW) - 1) / NUM_LINES + 1;
  localparam int TAG_W   = ($clog2(TAG_CNT) < 1) ? 1 : $clog2(TAG_CNT);
  // Exact reciprocal for dividing an AW-bit address by NUM_LINES.
  localparam int SH      = AW + IDX_W;
  localparam int PW      = SH + TAG_W;
  localparam longint unsigned RECIP_L = ((64'd1 << SH) + NUM_LINES - 1) / NUM_LINES;
  localparam logic [PW-1:0] RECIP = RECIP_L[PW-1:0];
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);
  localparam logic [QCNT_W-1:0] QFULL = QCNT_W'(QDEPTH);

  // Stage 1: classified item with the quotient of the address.
  logic              s1_valid_q, s1_valid_d;
  op_e               s1_op_q;
  logic [AW-1:0]     s1_addr_q;
  logic [TAG_W-1:0]  s1_quot_q;
  logic [DATA_W-1:0] s1_wdata_q, s1_mdata_q;

  op_e               op_dec;
  logic [PW-1:0]     prod;
  logic [AW-1:0]     s1_qn;
  logic [AW-1:0]     s1_rem;
  logic              accept, push, s1_ready;

  // Queue storage.
  q_head_t           q_ent_q [QDEPTH];
  logic [IDX_W-1:0]  q_idx_q [QDEPTH];
  logic [TAG_W-1:0]  q_tag_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              full;

  always_comb begin
    case (kind_i)
      KIND_LOAD:     op_dec = OP_LOAD;
      KIND_STORE:    op_dec = OP_STORE;
      KIND_SNP_RD:   op_dec = OP_SNP_RD;
      KIND_SNP_RDX:  op_dec = OP_SNP_RDX;
      KIND_SNP_UPGR: op_dec = OP_SNP_UPGR;
      default:       op_dec = OP_NONE;
    endcase
  end

  assign prod   = PW'(address_i[AW-1:0]) * RECIP;
  assign s1_qn  = AW'(AW'(s1_quot_q) * AW'(NUM_LINES));
  assign s1_rem = s1_addr_q - s1_qn;

  assign full       = (cnt_q == QFULL);
  assign push       = s1_valid_q && !full;
  assign s1_ready   = !s1_valid_q || push;
  assign in_ready_o = s1_ready && !status_i.clearing;
  assign accept     = in_valid_i && in_ready_o;

  assign s1_valid_d = accept ? 1'b1 : (push ? 1'b0 : s1_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_op_q    <= op_dec;
      s1_addr_q  <= address_i[AW-1:0];
      s1_quot_q  <= prod[SH +: TAG_W];
      s1_wdata_q <= write_data_i;
      s1_mdata_q <= mem_data_i;
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (push && !status_i.pop) begin
      cnt_d = cnt_q + QCNT_W'(1);
    end else if (!push && status_i.pop) begin
      cnt_d = cnt_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (status_i.pop) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_ent_q[wr_ptr_q] <= '{valid: 1'b1, op: s1_op_q, wdata: s1_wdata_q, mdata: s1_mdata_q};
      q_idx_q[wr_ptr_q] <= IDX_W'(s1_rem);
      q_tag_q[wr_ptr_q] <= s1_quot_q;
    end
  end

  always_comb begin
    head_o       = q_ent_q[rd_ptr_q];
    head_o.valid = (cnt_q != '0);
  end
  assign head_idx_o = q_idx_q[rd_ptr_q];
  assign head_tag_o = q_tag_q[rd_ptr_q];

`ifndef NO_ASSERTIONS
  // The engine only takes an entry that the queue actually holds.
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_i.pop |-> (cnt_q != '0))
    else $error("queue popped while empty");
`endif

endmodule : mdmc_front

`default_nettype wire

>>> design/mdmc_engine.sv
// ----------------------------------------------------------------------------
// MESI cache engine
// Holds the line store, clears it after reset, and carries out one queued
// access at a time: read the line, then update it and register the result.
// ----------------------------------------------------------------------------
`default_nettype none

module mdmc_engine
  import mdmc_pkg::*;
#(
  parameter int NUM_LINES = NUM_LINES_DEF,
  parameter int ADDR_BITS = ADDR_BITS_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire q_head_t             head_i,
  input  wire logic [$clog2(NUM_LINES)-1:0] head_idx_i,
  input  wire logic [((($clog2(((1 << ((ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W)) - 1)
                  / NUM_LINES + 1)) < 1) ? 1
                 : $clog2(((1 << ((ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W)) - 1)
                  / NUM_LINES + 1)) - 1:0] head_tag_i,
  output eng_status_t              status_o,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic [DATA_W-1:0]        read_data_o,
  output logic                     hit_o,
  output bus_req_e                 bus_request_o,
  output logic                     mem_write_o,
  output logic [DATA_W-1:0]        mem_write_data_o
);

  localparam int AW      = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
  localparam int IDX_W   = $clog2(NUM_LINES);
  localparam int TAG_CNT = ((1 << AW) - 1) / NUM_LINES + 1;
  localparam int TAG_W   = ($clog2(TAG_CNT) < 1) ? 1 : $clog2(TAG_CNT);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_LINES - 1);

  eng_state_e        state_q, state_d;
  logic [IDX_W-1:0]  clr_cnt_q, clr_cnt_d;

  // Line store.
  line_state_e       state_mem [NUM_LINES];
  logic [TAG_W-1:0]  tag_mem   [NUM_LINES];
  logic [DATA_W-1:0] data_mem  [NUM_LINES];

  // Access in flight and the line it read.
  op_e               cur_op_q;
  logic [IDX_W-1:0]  cur_idx_q;
  logic [TAG_W-1:0]  cur_tag_q;
  logic [DATA_W-1:0] cur_wdata_q, cur_mdata_q;
  line_state_e       rd_state_q;
  logic [TAG_W-1:0]  rd_tag_q;
  logic [DATA_W-1:0] rd_data_q;

  // Output register.
  logic              out_valid_q, out_valid_d;
  logic [DATA_W-1:0] rdata_q, mwdata_q;
  logic              hit_q, mw_q;
  bus_req_e          bus_q;

  logic              pop, clearing, exec_fire, out_free;
  logic              line_hit;
  line_state_e       new_state;
  logic              st_we, tag_we, data_we;
  logic [DATA_W-1:0] new_data;
  logic [DATA_W-1:0] res_rdata, res_mwdata;
  logic              res_hit, res_mw;
  bus_req_e          res_bus;

  assign out_free = !out_valid_q || out_ready_i;

  // Next state.
  always_comb begin
    state_d   = state_q;
    clr_cnt_d = clr_cnt_q;
    case (state_q)
      S_CLEAR: begin
        clr_cnt_d = clr_cnt_q + IDX_W'(1);
        if (clr_cnt_q == LAST_IDX) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (head_i.valid) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_CLEAR;
    endcase
  end

  // State outputs.
  always_comb begin
    clearing  = 1'b0;
    pop       = 1'b0;
    exec_fire = 1'b0;
    case (state_q)
      S_CLEAR: clearing  = 1'b1;
      S_IDLE:  pop       = head_i.valid;
      S_EXEC:  exec_fire = out_free;
      default: clearing  = 1'b0;
    endcase
  end

  assign status_o = '{clearing: clearing, pop: pop};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      clr_cnt_q <= '0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
    end
  end

  // Protocol actions for the line that was read.
  always_comb begin
    line_hit   = (rd_state_q != ST_INVALID) && (rd_tag_q == cur_tag_q);
    new_state  = rd_state_q;
    st_we      = 1'b0;
    tag_we     = 1'b0;
    data_we    = 1'b0;
    new_data   = cur_wdata_q;
    res_rdata  = '0;
    res_mwdata = '0;
    res_hit    = line_hit;
    res_mw     = 1'b0;
    res_bus    = BUS_NONE;
    case (cur_op_q)
      OP_LOAD: begin
        if (line_hit) begin
          res_rdata = rd_data_q;
        end else begin
          res_bus   = BUS_RD;
          new_data  = cur_mdata_q;
          new_state = ST_EXCLUSIVE;
          st_we     = 1'b1;
          tag_we    = 1'b1;
          data_we   = 1'b1;
          res_rdata = cur_mdata_q;
        end
      end
      OP_STORE: begin
        if (!line_hit) begin
          res_bus = BUS_RDX;
          tag_we  = 1'b1;
        end else if (rd_state_q == ST_SHARED) begin
          res_bus = BUS_UPGR;
        end
        new_state  = ST_MODIFIED;
        st_we      = 1'b1;
        data_we    = 1'b1;
        res_mw     = 1'b1;
        res_mwdata = cur_wdata_q;
      end
      OP_SNP_RD, OP_SNP_RDX: begin
        if (line_hit) begin
          if (rd_state_q == ST_MODIFIED) begin
            res_mw     = 1'b1;
            res_mwdata = rd_data_q;
          end
          new_state = (cur_op_q == OP_SNP_RD) ? ST_SHARED : ST_INVALID;
          st_we     = 1'b1;
        end
      end
      OP_SNP_UPGR: begin
        if (line_hit && rd_state_q == ST_SHARED) begin
          new_state = ST_INVALID;
          st_we     = 1'b1;
        end
      end
      default: res_hit = 1'b0;
    endcase
  end

  // Line store: clearing pass, update on completion, read on pop.
  always_ff @(posedge clk_i) begin
    if (clearing) begin
      state_mem[clr_cnt_q] <= ST_INVALID;
    end else if (exec_fire && st_we) begin
      state_mem[cur_idx_q] <= new_state;
    end
    if (exec_fire && tag_we) begin
      tag_mem[cur_idx_q] <= cur_tag_q;
    end
    if (exec_fire && data_we) begin
      data_mem[cur_idx_q] <= new_data;
    end
    if (pop) begin
      rd_state_q <= state_mem[head_idx_i];
      rd_tag_q   <= tag_mem[head_idx_i];
      rd_data_q  <= data_mem[head_idx_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      cur_op_q    <= head_i.op;
      cur_idx_q   <= head_idx_i;
      cur_tag_q   <= head_tag_i;
      cur_wdata_q <= head_i.wdata;
      cur_mdata_q <= head_i.mdata;
    end
  end

  assign out_valid_d = exec_fire ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec_fire) begin
      rdata_q  <= res_rdata;
      hit_q    <= res_hit;
      bus_q    <= res_bus;
      mw_q     <= res_mw;
      mwdata_q <= res_mwdata;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign read_data_o      = rdata_q;
  assign hit_o            = hit_q;
  assign bus_request_o    = bus_q;
  assign mem_write_o      = mw_q;
  assign mem_write_data_o = mwdata_q;

`ifndef NO_ASSERTIONS
  // Write data is only shown together with a memory write.
  a_mwdata_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !mw_q) |-> (mwdata_q == '0))
    else $error("memory write data without a memory write");

  // An upgrade only comes from a store that hit a line.
  a_upgr_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && bus_q == BUS_UPGR) |-> (hit_q && mw_q))
    else $error("upgrade issued without a store hit");

  // Fills are requested only on a miss.
  a_fill_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (bus_q == BUS_RD || bus_q == BUS_RDX)) |-> !hit_q)
    else $error("fill requested on a hit");

  // No access is started while the line store is being cleared.
  a_no_pop_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |=> !($past(pop)))
    else $error("access started during clearing pass");
`endif

endmodule : mdmc_engine

`default_nettype wire
